/* rtl/lodd_pkg.sv */
// ----------------------------------------------------------------------------
// Lock-order deadlock detector package
// Status codes and the handshake group between the controller and the search.
// ----------------------------------------------------------------------------
`default_nettype none

package lodd_pkg;

  typedef logic [2:0] status_t;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_DEADLOCK  = 3'd1;
  localparam status_t ST_MULTI_UNL = 3'd2;
  localparam status_t ST_BAD_UNL   = 3'd3;
  localparam status_t ST_FULL      = 3'd4;
  localparam status_t ST_HALTED    = 3'd5;

  localparam int unsigned LOCK_ID_W = 4;

  typedef struct packed {
    logic done;
    logic found;
  } search_status_t;

endpackage

`default_nettype wire

/* rtl/lodd_graph.sv */
// ----------------------------------------------------------------------------
// Lock-order graph memory
// Adjacency rows with one write port and one registered read port; per-row
// valid bits make every row read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lodd_graph #(
  parameter int unsigned MAX_LOCKS = 16,
  parameter int unsigned LW        = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 we,
  input  wire logic [LW-1:0]        waddr,
  input  wire logic [MAX_LOCKS-1:0] wdata,
  input  wire logic                 re,
  input  wire logic [LW-1:0]        raddr,
  output logic      [MAX_LOCKS-1:0] rdata
);

  logic [MAX_LOCKS-1:0] mem [MAX_LOCKS];
  logic [MAX_LOCKS-1:0] row_valid;
  logic [MAX_LOCKS-1:0] data_q;
  logic                 valid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (we) begin
      row_valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      data_q  <= mem[raddr];
      valid_q <= row_valid[raddr];
    end
  end

  assign rdata = data_q & {MAX_LOCKS{valid_q}};

endmodule

`default_nettype wire

/* rtl/lodd_search.sv */
// ----------------------------------------------------------------------------
// Depth-first cycle search
// Walks the graph one adjacency bit per cycle while it scans a row, with an
// explicit path stack, and stops at the first edge into a vertex whose search
// is still open.
`default_nettype none

module lodd_search
  import lodd_pkg::*;
#(
  parameter int unsigned MAX_LOCKS = 16,
  parameter int unsigned LW        = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      rd_en,
  output logic      [LW-1:0]        rd_addr,
  input  wire logic [MAX_LOCKS-1:0] rd_row,
  output search_status_t            status,
  output logic      [LW-1:0]        from_v,
  output logic      [LW-1:0]        to_v
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ROOT = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_POP  = 2'd3;

  localparam logic [LW:0] NBR_END = (LW+1)'(MAX_LOCKS);

  logic [1:0]           state;
  logic [LW:0]          root;
  logic [LW:0]          nbr;
  logic [LW-1:0]        cur;
  logic [LW-1:0]        depth;
  logic [MAX_LOCKS-1:0] seen;
  logic [MAX_LOCKS-1:0] open_v;
  logic                 done;
  logic                 found;

  logic [LW-1:0] path_mem [MAX_LOCKS];
  logic [LW-1:0] path_q;

  logic [LW-1:0] ridx;
  logic [LW-1:0] nidx;
  logic          scan_end;
  logic          nbit;
  logic          push_go;
  logic          pop_go;

  assign ridx     = root[LW-1:0];
  assign nidx     = nbr[LW-1:0];
  assign scan_end = (nbr == NBR_END);
  assign nbit     = rd_row[nidx];
  assign push_go  = (state == S_SCAN) && !scan_end && nbit && !seen[nidx];
  assign pop_go   = (state == S_SCAN) && scan_end && (depth != '0);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ridx;
    unique case (state)
      S_IDLE: begin
        rd_en = 1'b0;
      end
      S_ROOT: begin
        rd_en   = (root != NBR_END) && !seen[ridx];
        rd_addr = ridx;
      end
      S_SCAN: begin
        rd_en   = push_go;
        rd_addr = nidx;
      end
      S_POP: begin
        rd_en   = 1'b1;
        rd_addr = path_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (push_go) begin
      path_mem[depth] <= cur;
    end
    if (pop_go) begin
      path_q <= path_mem[depth - 1'b1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      found <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            seen   <= '0;
            open_v <= '0;
            root   <= '0;
            found  <= 1'b0;
            state  <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (root == NBR_END) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (seen[ridx]) begin
            root <= root + 1'b1;
          end else begin
            cur          <= ridx;
            seen[ridx]   <= 1'b1;
            open_v[ridx] <= 1'b1;
            depth        <= '0;
            nbr          <= '0;
            state        <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            open_v[cur] <= 1'b0;
            if (depth == '0) begin
              root  <= root + 1'b1;
              state <= S_ROOT;
            end else begin
              state <= S_POP;
            end
          end else if (!nbit) begin
            nbr <= nbr + 1'b1;
          end else if (!seen[nidx]) begin
            depth        <= depth + 1'b1;
            cur          <= nidx;
            seen[nidx]   <= 1'b1;
            open_v[nidx] <= 1'b1;
            nbr          <= '0;
          end else if (open_v[nidx]) begin
            found  <= 1'b1;
            from_v <= cur;
            to_v   <= nidx;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            nbr <= nbr + 1'b1;
          end
        end
        S_POP: begin
          cur   <= path_q;
          nbr   <= {1'b0, cur} + 1'b1;
          depth <= depth - 1'b1;
          state <= S_SCAN;
        end
      endcase
    end
  end

  assign status.done  = done;
  assign status.found = found;

endmodule

`default_nettype wire

/* rtl/lock_order_deadlock_detector_unit.sv */
// ----------------------------------------------------------------------------
// Lock-order deadlock detector
// Tracks held locks on a stack, records lock-order edges in an adjacency
// memory and searches the graph for a cycle whenever a new edge appears.
//
//   Channel   Handshake           Word
//   request   start / busy        req_type, lock_id
//   result    done (one cycle)    status, edge_added, cycle_from, cycle_to
//
// A release, a halted request or an acquire with no new edge ends without the
// search. An acquire that records a new edge also runs the search, which reads
// one adjacency bit per cycle while it scans, via the single graph read port.
// Reset clears the graph at once through per-row valid bits; no clearing pass.
// The result is shown for one cycle with done; the receiver cannot stall it.
// ----------------------------------------------------------------------------
`default_nettype none

module lock_order_deadlock_detector_unit
  import lodd_pkg::*;
#(
  parameter int unsigned MAX_LOCKS   = 16,
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       req_type,
  input  wire logic [3:0] lock_id,
  output logic            done,
  output logic      [2:0] status,
  output logic            edge_added,
  output logic      [3:0] cycle_from,
  output logic      [3:0] cycle_to
);

  localparam int unsigned LW  = $clog2(MAX_LOCKS);
  localparam int unsigned W   = (LW > LOCK_ID_W) ? LW : LOCK_ID_W;
  localparam int unsigned CW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic [W:0]    LOCK_LIMIT = (W+1)'(MAX_LOCKS);
  localparam logic [CW-1:0] DEPTH_MAX  = CW'(STACK_DEPTH);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_TOP  = 2'd1;
  localparam logic [1:0] C_ROW  = 2'd2;
  localparam logic [1:0] C_SRCH = 2'd3;

  logic [1:0]    state;
  logic          halted;
  logic [CW-1:0] count;
  logic          req_q;
  logic [W-1:0]  id_q;
  logic [LW-1:0] top_q;

  logic [LW-1:0] stack_mem [STACK_DEPTH];
  logic [LW-1:0] stk_q;
  logic          stk_re;
  logic [CW-1:0] count_m1;

  logic [W-1:0]  id_w;
  logic          id_ok;
  logic [LW-1:0] lidx;
  logic [LW-1:0] lidx_q;
  logic          top_match;

  logic          push_en;
  logic [LW-1:0] push_idx;

  logic                 g_we;
  logic [MAX_LOCKS-1:0] g_wdata;
  logic                 g_re;
  logic [LW-1:0]        g_raddr;
  logic                 c_re;
  logic [LW-1:0]        c_raddr;
  logic [MAX_LOCKS-1:0] g_rdata;

  logic           srch_start;
  logic           s_re;
  logic [LW-1:0]  s_raddr;
  search_status_t s_status;
  logic [LW-1:0]  s_from;
  logic [LW-1:0]  s_to;
  logic [W-1:0]   s_from_w;
  logic [W-1:0]   s_to_w;

  assign id_w      = W'(lock_id);
  assign id_ok     = ({1'b0, id_w} < LOCK_LIMIT);
  assign lidx      = id_w[LW-1:0];
  assign lidx_q    = id_q[LW-1:0];
  assign top_match = (W'(stk_q) == id_q);
  assign count_m1  = count - 1'b1;
  assign s_from_w  = W'(s_from);
  assign s_to_w    = W'(s_to);
  assign busy      = (state != C_IDLE);

  always_comb begin
    push_en    = 1'b0;
    push_idx   = lidx_q;
    stk_re     = 1'b0;
    c_re       = 1'b0;
    c_raddr    = stk_q;
    g_we       = 1'b0;
    g_wdata    = g_rdata | (MAX_LOCKS'(1) << lidx_q);
    srch_start = 1'b0;
    unique case (state)
      C_IDLE: begin
        push_idx = lidx;
        if (start && !halted) begin
          if (req_type) begin
            stk_re = (count != '0);
          end else if (id_ok && (count < DEPTH_MAX)) begin
            stk_re  = (count != '0);
            push_en = (count == '0);
          end
        end
      end
      C_TOP: begin
        if (!req_q) begin
          push_en = top_match;
          c_re    = !top_match;
        end
      end
      C_ROW: begin
        if (g_rdata[lidx_q]) begin
          push_en = 1'b1;
        end else begin
          g_we       = 1'b1;
          srch_start = 1'b1;
        end
      end
      C_SRCH: begin
        push_en = s_status.done && !s_status.found;
      end
    endcase
  end

  assign g_re    = (state == C_SRCH) ? s_re : c_re;
  assign g_raddr = (state == C_SRCH) ? s_raddr : c_raddr;

  always_ff @(posedge clk) begin
    if (push_en) begin
      stack_mem[count[SAW-1:0]] <= push_idx;
    end
    if (stk_re) begin
      stk_q <= stack_mem[count_m1[SAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= C_IDLE;
      halted <= 1'b0;
      count  <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (push_en) begin
        count <= count + 1'b1;
      end
      unique case (state)
        C_IDLE: begin
          if (start) begin
            req_q      <= req_type;
            id_q       <= id_w;
            status     <= ST_OK;
            edge_added <= 1'b0;
            cycle_from <= '0;
            cycle_to   <= '0;
            if (halted) begin
              status <= ST_HALTED;
              done   <= 1'b1;
            end else if (req_type) begin
              if (count == '0) begin
                status <= ST_MULTI_UNL;
                halted <= 1'b1;
                done   <= 1'b1;
              end else begin
                state <= C_TOP;
              end
            end else if (!id_ok || (count == '0)) begin
              done <= 1'b1;
            end else if (count >= DEPTH_MAX) begin
              status <= ST_FULL;
              halted <= 1'b1;
              done   <= 1'b1;
            end else begin
              state <= C_TOP;
            end
          end
        end
        C_TOP: begin
          top_q <= stk_q;
          if (req_q) begin
            if (!top_match) begin
              status <= ST_BAD_UNL;
              halted <= 1'b1;
            end else begin
              count <= count - 1'b1;
            end
            done  <= 1'b1;
            state <= C_IDLE;
          end else if (top_match) begin
            done  <= 1'b1;
            state <= C_IDLE;
          end else begin
            state <= C_ROW;
          end
        end
        C_ROW: begin
          if (g_rdata[lidx_q]) begin
            done  <= 1'b1;
            state <= C_IDLE;
          end else begin
            edge_added <= 1'b1;
            state      <= C_SRCH;
          end
        end
        C_SRCH: begin
          if (s_status.done) begin
            if (s_status.found) begin
              status     <= ST_DEADLOCK;
              cycle_from <= s_from_w[3:0];
              cycle_to   <= s_to_w[3:0];
              halted     <= 1'b1;
            end
            done  <= 1'b1;
            state <= C_IDLE;
          end
        end
      endcase
    end
  end

  lodd_graph #(
    .MAX_LOCKS(MAX_LOCKS),
    .LW       (LW)
  ) u_graph (
    .clk  (clk),
    .rst  (rst),
    .we   (g_we),
    .waddr(top_q),
    .wdata(g_wdata),
    .re   (g_re),
    .raddr(g_raddr),
    .rdata(g_rdata)
  );

  lodd_search #(
    .MAX_LOCKS(MAX_LOCKS),
    .LW       (LW)
  ) u_search (
    .clk    (clk),
    .rst    (rst),
    .start  (srch_start),
    .rd_en  (s_re),
    .rd_addr(s_raddr),
    .rd_row (g_rdata),
    .status (s_status),
    .from_v (s_from),
    .to_v   (s_to)
  );

endmodule

`default_nettype wire
